/* src/slot_allocator_wear_counter_assert.svh */
// Assertion macros used by the slot allocator's top-level RTL file.
`ifndef SLOT_ALLOCATOR_WEAR_COUNTER_ASSERT_SVH
`define SLOT_ALLOCATOR_WEAR_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold after the antecedent, not in the same cycle.
`define SWC_ASSERT_AFTER2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

/* src/swc_pkg.sv */
// Shared constants, codes and beat types of the slot allocator with wear counters.
package swc_pkg;

  localparam int NUM_SLOTS_DEF   = 1024;
  localparam int MAX_ORDER_DEF   = 15;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int MODE_W   = 4;
  localparam int SLOT_W   = 10;
  localparam int WORD_W   = 5;
  localparam int STATUS_W = 3;
  localparam int VALUE_W  = 64;
  localparam int ORDER_W  = 4;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd15;

  localparam logic [MODE_W-1:0] MODE_ALLOC      = 4'd0;
  localparam logic [MODE_W-1:0] MODE_FREE       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_KEY_WR     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_PTR_WR     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BUMP       = 4'd4;
  localparam logic [MODE_W-1:0] MODE_RD_NODE    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_RD_ALLOC   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_RD_WORD    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_RD_SUM     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_TOT_ALLOCS = 4'd9;
  localparam logic [MODE_W-1:0] MODE_TOT_WRITES = 4'd10;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_WRONG_KIND = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD_WORD   = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] word_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [VALUE_W-1:0]  count_value;
  } out_item_t;

  typedef struct packed {
    logic pop;
    logic push;
  } fl_ctrl_t;

  typedef struct packed {
    logic ready;
    logic empty;
    logic full;
  } fl_stat_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } cs_cmd_t;

endpackage

/* src/slot_allocator_wear_counter.sv */
// Top level of the slot allocator with wear counters: command sequencer and totals.
//
// Channel  Ports                                   Beat taken at the edge where
// input    start, busy, in_item                    start is high and busy is low
// result   out_strobe, out_item                    out_strobe is high (one cycle)
// config   cfg_valid, cfg_ready, cfg_tree_order    cfg_valid and cfg_ready are high
//
// Errors, free, total reads and unused modes finish in the idle state; counter reads, word writes
// and node bumps take a memory read, then write back or return; allocate pops the free list first.
// A slot sum then returns the sum of the slot's words, one word per counter memory read.
// After reset a clearing pass over all NUM_SLOTS << CIDX_W counter words (65536 at the defaults)
// runs with busy high; cfg_ready stays high throughout.
// The result appears the cycle after the last cycle of its item; it cannot be stalled.

`include "slot_allocator_wear_counter_assert.svh"

module slot_allocator_wear_counter #(
  parameter int NUM_SLOTS   = swc_pkg::NUM_SLOTS_DEF,
  parameter int MAX_ORDER   = swc_pkg::MAX_ORDER_DEF,
  parameter int COUNT_WIDTH = swc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  swc_pkg::in_item_t                in_item,
  output logic                             out_strobe,
  output swc_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swc_pkg::ORDER_W-1:0]      cfg_tree_order
);

  localparam int SLOT_AW   = $clog2(NUM_SLOTS);
  localparam int WORDS_MAX = 2 * MAX_ORDER + 1;
  // Word counters plus one node and one allocation counter per slot.
  localparam int CIDX_W    = $clog2(WORDS_MAX + 2);
  localparam int ADDR_W    = SLOT_AW + CIDX_W;
  localparam int VW        = swc_pkg::VALUE_W;

  localparam logic [CIDX_W-1:0] NODE_SEL  = CIDX_W'(WORDS_MAX);
  localparam logic [CIDX_W-1:0] ALLOC_SEL = CIDX_W'(WORDS_MAX + 1);

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_POP  = 6'b000100,
    ST_RMW  = 6'b001000,
    ST_READ = 6'b010000,
    ST_SUM  = 6'b100000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [swc_pkg::ORDER_W-1:0]      tree_order_r;
  logic [VW-1:0]                    total_allocs_r, allocs_nxt;
  logic [VW-1:0]                    total_writes_r, writes_nxt;
  logic [ADDR_W-1:0]                addr_r, addr_nxt;
  logic [SLOT_AW-1:0]               slot_r, slot_nxt;
  logic [swc_pkg::STATUS_W-1:0]     op_status_r, op_status_nxt;
  logic [CIDX_W-1:0]                idx_r, idx_nxt;
  logic [VW-1:0]                    sum_r, sum_nxt;
  logic [SLOT_AW-1:0]               sum_slot_r, sum_slot_nxt;
  logic                             out_strobe_r;
  swc_pkg::out_item_t               out_item_r;

  swc_pkg::fl_ctrl_t                fl_ctrl;
  swc_pkg::fl_stat_t                fl_stat;
  logic [SLOT_AW-1:0]               fl_pop_slot;
  logic [SLOT_AW-1:0]               slot_a;
  swc_pkg::cs_cmd_t                 cs_cmd;
  logic [ADDR_W-1:0]                cs_raddr;
  logic [COUNT_WIDTH-1:0]           cs_rdata;
  logic [COUNT_WIDTH-1:0]           cnt_inc;
  logic                             cs_ready;

  logic [6:0]                       ord_eff;
  logic [CIDX_W-1:0]                words;
  logic [CIDX_W-1:0]                word_a;
  logic                             slot_ok;
  logic                             word_ok;
  logic                             slot_mode;
  logic [VW:0]                      sum_add;
  logic [VW-1:0]                    sum_sat;
  logic [VW-1:0]                    allocs_inc;
  logic [VW-1:0]                    writes_inc;
  logic                             emit;
  swc_pkg::out_item_t               res;

  swc_free_list #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_AW   (SLOT_AW)
  ) u_free_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fl_ctrl),
    .push_slot (slot_a),
    .pop_slot  (fl_pop_slot),
    .stat      (fl_stat)
  );

  swc_counter_store #(
    .NUM_SLOTS   (NUM_SLOTS),
    .SLOT_AW     (SLOT_AW),
    .CIDX_W      (CIDX_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counter_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cs_cmd),
    .raddr (cs_raddr),
    .waddr (addr_r),
    .wdata (cnt_inc),
    .rdata (cs_rdata),
    .ready (cs_ready)
  );

  // Words per slot follow the node order, capped at the built maximum.
  assign ord_eff = (7'(tree_order_r) > 7'(MAX_ORDER)) ? 7'(MAX_ORDER) : 7'(tree_order_r);
  assign words   = CIDX_W'({ord_eff, 1'b1});

  assign slot_a    = SLOT_AW'(in_item.slot_index);
  assign word_a    = CIDX_W'(in_item.word_index);
  assign slot_ok   = 32'(in_item.slot_index) < 32'(NUM_SLOTS);
  assign word_ok   = 32'(in_item.word_index) < 32'(words);
  assign slot_mode = in_item.mode inside {[swc_pkg::MODE_FREE:swc_pkg::MODE_RD_SUM]};

  assign cnt_inc    = (&cs_rdata) ? cs_rdata : cs_rdata + COUNT_WIDTH'(1);
  assign allocs_inc = (&total_allocs_r) ? total_allocs_r : total_allocs_r + VW'(1);
  assign writes_inc = (&total_writes_r) ? total_writes_r : total_writes_r + VW'(1);
  assign sum_add    = {1'b0, sum_r} + (VW + 1)'(cs_rdata);
  assign sum_sat    = sum_add[VW] ? '1 : sum_add[VW-1:0];

  always_comb begin
    state_nxt     = state_r;
    allocs_nxt    = total_allocs_r;
    writes_nxt    = total_writes_r;
    addr_nxt      = addr_r;
    slot_nxt      = slot_r;
    op_status_nxt = op_status_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    sum_slot_nxt  = sum_slot_r;
    fl_ctrl       = '0;
    cs_cmd        = '0;
    cs_raddr      = '0;
    res           = '0;
    emit          = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        if (fl_stat.ready && cs_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          emit          = 1'b1;
          slot_nxt      = '0;
          op_status_nxt = swc_pkg::STATUS_OK;
          if (slot_mode && !slot_ok) begin
            res.status = swc_pkg::STATUS_BAD_SLOT;
          end else begin
            unique case (in_item.mode) inside
              swc_pkg::MODE_ALLOC: begin
                if (fl_stat.empty) begin
                  res.status = swc_pkg::STATUS_EMPTY;
                end else begin
                  fl_ctrl.pop = 1'b1;
                  allocs_nxt  = allocs_inc;
                  emit        = 1'b0;
                  state_nxt   = ST_POP;
                end
              end
              swc_pkg::MODE_FREE: begin
                if (fl_stat.full) begin
                  res.status = swc_pkg::STATUS_FULL;
                end else begin
                  fl_ctrl.push = 1'b1;
                end
              end
              swc_pkg::MODE_KEY_WR, swc_pkg::MODE_PTR_WR: begin
                if (!word_ok) begin
                  res.status = swc_pkg::STATUS_BAD_WORD;
                end else begin
                  // Keys live at odd words and pointers at even words; a mismatch
                  // is still counted but reported.
                  if ((in_item.mode == swc_pkg::MODE_KEY_WR) != in_item.word_index[0]) begin
                    op_status_nxt = swc_pkg::STATUS_WRONG_KIND;
                  end
                  cs_cmd.rd  = 1'b1;
                  cs_raddr   = {slot_a, word_a};
                  addr_nxt   = {slot_a, word_a};
                  writes_nxt = writes_inc;
                  emit       = 1'b0;
                  state_nxt  = ST_RMW;
                end
              end
              swc_pkg::MODE_BUMP: begin
                cs_cmd.rd = 1'b1;
                cs_raddr  = {slot_a, NODE_SEL};
                addr_nxt  = {slot_a, NODE_SEL};
                emit      = 1'b0;
                state_nxt = ST_RMW;
              end
              swc_pkg::MODE_RD_NODE: begin
                cs_cmd.rd = 1'b1;
                cs_raddr  = {slot_a, NODE_SEL};
                emit      = 1'b0;
                state_nxt = ST_READ;
              end
              swc_pkg::MODE_RD_ALLOC: begin
                cs_cmd.rd = 1'b1;
                cs_raddr  = {slot_a, ALLOC_SEL};
                emit      = 1'b0;
                state_nxt = ST_READ;
              end
              swc_pkg::MODE_RD_WORD: begin
                if (!word_ok) begin
                  res.status = swc_pkg::STATUS_BAD_WORD;
                end else begin
                  cs_cmd.rd = 1'b1;
                  cs_raddr  = {slot_a, word_a};
                  emit      = 1'b0;
                  state_nxt = ST_READ;
                end
              end
              swc_pkg::MODE_RD_SUM: begin
                cs_cmd.rd    = 1'b1;
                cs_raddr     = {slot_a, CIDX_W'(0)};
                idx_nxt      = CIDX_W'(1);
                sum_nxt      = '0;
                sum_slot_nxt = slot_a;
                emit         = 1'b0;
                state_nxt    = ST_SUM;
              end
              swc_pkg::MODE_TOT_ALLOCS: begin
                res.count_value = total_allocs_r;
              end
              swc_pkg::MODE_TOT_WRITES: begin
                res.count_value = total_writes_r;
              end
              default: begin
                res.status = swc_pkg::STATUS_OK;
              end
            endcase
          end
        end
      end

      ST_POP: begin
        // The popped slot is out of the free-list memory; fetch its allocation count.
        cs_cmd.rd = 1'b1;
        cs_raddr  = {fl_pop_slot, ALLOC_SEL};
        addr_nxt  = {fl_pop_slot, ALLOC_SEL};
        slot_nxt  = fl_pop_slot;
        state_nxt = ST_RMW;
      end

      ST_RMW: begin
        cs_cmd.wr        = 1'b1;
        emit             = 1'b1;
        res.status       = op_status_r;
        res.granted_slot = swc_pkg::SLOT_W'(slot_r);
        state_nxt        = ST_IDLE;
      end

      ST_READ: begin
        emit            = 1'b1;
        res.count_value = VW'(cs_rdata);
        state_nxt       = ST_IDLE;
      end

      ST_SUM: begin
        if (idx_r < words) begin
          cs_cmd.rd = 1'b1;
          cs_raddr  = {sum_slot_r, idx_r};
          idx_nxt   = idx_r + CIDX_W'(1);
          sum_nxt   = sum_sat;
        end else begin
          emit            = 1'b1;
          res.count_value = sum_sat;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_INIT;
      tree_order_r   <= swc_pkg::ORDER_RESET;
      total_allocs_r <= '0;
      total_writes_r <= '0;
      out_strobe_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      total_allocs_r <= allocs_nxt;
      total_writes_r <= writes_nxt;
      out_strobe_r   <= emit;
      if (cfg_valid && cfg_ready) begin
        tree_order_r <= cfg_tree_order;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    slot_r      <= slot_nxt;
    op_status_r <= op_status_nxt;
    idx_r       <= idx_nxt;
    sum_r       <= sum_nxt;
    sum_slot_r  <= sum_slot_nxt;
    if (emit) begin
      out_item_r <= res;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `SWC_ASSERT_NOW(a_init_silent, state_r == ST_INIT, !out_strobe_r,
    "result beat during the clearing pass")
  `SWC_ASSERT_AFTER2(a_bump_latency, start && !busy && in_item.mode == swc_pkg::MODE_BUMP && slot_ok,
    out_strobe_r, "node bump result not delivered two cycles after its beat")
  `SWC_ASSERT_NOW(a_grant_ok, out_strobe_r && out_item_r.granted_slot != '0,
    out_item_r.status == swc_pkg::STATUS_OK, "slot granted with an error status")

endmodule

/* src/swc_free_list.sv */
// FIFO free list of slot numbers held in a synchronous memory, with its fill pass.
module swc_free_list #(
  parameter int NUM_SLOTS = swc_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_AW   = $clog2(NUM_SLOTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swc_pkg::fl_ctrl_t  ctrl,
  input  logic [SLOT_AW-1:0] push_slot,
  output logic [SLOT_AW-1:0] pop_slot,
  output swc_pkg::fl_stat_t  stat
);

  localparam logic [SLOT_AW-1:0] LAST       = SLOT_AW'(NUM_SLOTS - 1);
  localparam logic [SLOT_AW:0]   FULL_COUNT = (SLOT_AW + 1)'(NUM_SLOTS);

  logic [SLOT_AW-1:0] mem [NUM_SLOTS];

  logic [SLOT_AW-1:0] head_r, head_nxt;
  logic [SLOT_AW-1:0] tail_r, tail_nxt;
  logic [SLOT_AW-1:0] clr_r, clr_nxt;
  logic [SLOT_AW:0]   count_r, count_nxt;
  logic               init_r, init_nxt;
  logic [SLOT_AW-1:0] pop_slot_r;
  logic               we;
  logic [SLOT_AW-1:0] waddr;
  logic [SLOT_AW-1:0] wdata;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    clr_nxt   = clr_r;
    init_nxt  = init_r;
    // After reset every entry is loaded with its own index, one per cycle.
    if (init_r) begin
      clr_nxt = clr_r + SLOT_AW'(1);
      if (clr_r == LAST) begin
        init_nxt = 1'b0;
      end
    end
    if (ctrl.pop) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + SLOT_AW'(1);
      count_nxt = count_r - (SLOT_AW + 1)'(1);
    end
    if (ctrl.push) begin
      tail_nxt  = (tail_r == LAST) ? '0 : tail_r + SLOT_AW'(1);
      count_nxt = count_r + (SLOT_AW + 1)'(1);
    end
  end

  assign we    = init_r || ctrl.push;
  assign waddr = init_r ? clr_r : tail_r;
  assign wdata = init_r ? clr_r : push_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= FULL_COUNT;
      clr_r   <= '0;
      init_r  <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      clr_r   <= clr_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.pop) begin
      pop_slot_r <= mem[head_r];
    end
  end

  assign pop_slot   = pop_slot_r;
  assign stat.ready = !init_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_COUNT);

endmodule

/* src/swc_counter_store.sv */
// Counter memory: per-slot word, node and allocation counters, with a clearing pass.
module swc_counter_store #(
  parameter int NUM_SLOTS   = swc_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_AW     = $clog2(NUM_SLOTS),
  parameter int CIDX_W      = 5,
  parameter int COUNT_WIDTH = swc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  swc_pkg::cs_cmd_t          cmd,
  input  logic [SLOT_AW+CIDX_W-1:0] raddr,
  input  logic [SLOT_AW+CIDX_W-1:0] waddr,
  input  logic [COUNT_WIDTH-1:0]    wdata,
  output logic [COUNT_WIDTH-1:0]    rdata,
  output logic                      ready
);

  localparam int                ADDR_W = SLOT_AW + CIDX_W;
  localparam int                DEPTH  = NUM_SLOTS << CIDX_W;
  localparam logic [ADDR_W-1:0] LAST   = ADDR_W'(DEPTH - 1);

  logic [COUNT_WIDTH-1:0] mem [DEPTH];

  logic [ADDR_W-1:0]      clr_r, clr_nxt;
  logic                   init_r, init_nxt;
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic                   we;
  logic [ADDR_W-1:0]      wa;
  logic [COUNT_WIDTH-1:0] wd;

  always_comb begin
    clr_nxt  = clr_r;
    init_nxt = init_r;
    if (init_r) begin
      clr_nxt = clr_r + ADDR_W'(1);
      if (clr_r == LAST) begin
        init_nxt = 1'b0;
      end
    end
  end

  assign we = init_r || cmd.wr;
  assign wa = init_r ? clr_r : waddr;
  assign wd = init_r ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      init_r <= 1'b1;
    end else begin
      clr_r  <= clr_nxt;
      init_r <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
  assign ready = !init_r;

endmodule
